@@ rtl/core/imucf_pkg.sv @@
// shared types, constants and table for the imu complementary filter
package imucf_pkg;

    localparam int AXIS_W  = 16;
    localparam int SEED_W  = AXIS_W + 1;
    localparam int ANGLE_W = 32;
    localparam int GSUM_W  = ANGLE_W + 2;
    localparam int BW_W    = 17;
    localparam int GAIN_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [BW_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [BW_W-1:0] BW_RESET    = 17'd58982;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd83886;

    // queue between front and back, power of two
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // atan(2^-i) in degrees, q.24
    localparam int ATAN_TAB_LEN = 24;
    localparam logic [29:0] ATAN_DEG_Q24 [ATAN_TAB_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489089, 30'd119537938, 30'd60000934,
        30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
        30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671,
        30'd29335, 30'd14668, 30'd7334, 30'd3667, 30'd1833,
        30'd917, 30'd458, 30'd229, 30'd115
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_WEIGHT,
        REG_GYRO_GAIN
    } t_cfg_reg;

    // quarter turn applied before the cordic when x is negative
    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_POS,
        ROT_NEG
    } t_prerot;

    typedef struct packed {
        logic signed [SEED_W-1:0] x;
        logic signed [SEED_W-1:0] y;
        t_prerot                  rot;
        logic                     zero;
    } t_seed;

    typedef struct packed {
        t_seed                    pitch;
        t_seed                    roll;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_BLEND,
        ST_DONE
    } t_back_state;

    // table entry rounded half up to frac_bits fraction bits
    function automatic logic [29:0] atan_step(input logic [4:0] idx, input int frac_bits);
        logic [30:0] v;
        int          sh;
        v  = {1'b0, ATAN_DEG_Q24[idx]};
        sh = 24 - frac_bits;
        v  = v + (31'd1 << (sh - 1));
        return 30'(v >> sh);
    endfunction

endpackage

@@ rtl/core/imucf_front.sv @@
// front part: takes samples, classifies both atan2 operand pairs, pushes jobs
module imucf_front
    import imucf_pkg::*;
(
    input  logic                     i_in_valid,
    input  logic signed [AXIS_W-1:0] i_accel_x,
    input  logic signed [AXIS_W-1:0] i_accel_y,
    input  logic signed [AXIS_W-1:0] i_accel_z,
    input  logic signed [AXIS_W-1:0] i_gyro_x,
    input  logic signed [AXIS_W-1:0] i_gyro_y,
    input  logic signed [AXIS_W-1:0] i_gyro_z,
    input  t_queue_status            i_queue,
    output logic                     o_in_stall,
    output logic                     o_push,
    output t_job                     o_job
);

    // zero vector flag and quarter-turn pre-rotation into the right half plane
    function automatic t_seed classify(input logic signed [SEED_W-1:0] xin,
                                       input logic signed [SEED_W-1:0] yin);
        t_seed s;
        s.zero = (xin == '0) && (yin == '0);
        if (xin < 0) begin
            if (yin >= 0) begin
                s.x   = yin;
                s.y   = -xin;
                s.rot = ROT_POS;
            end else begin
                s.x   = -yin;
                s.y   = xin;
                s.rot = ROT_NEG;
            end
        end else begin
            s.x   = xin;
            s.y   = yin;
            s.rot = ROT_NONE;
        end
        return s;
    endfunction

    logic signed [SEED_W-1:0] c_ax;
    logic signed [SEED_W-1:0] c_ay;
    logic signed [SEED_W-1:0] c_az;

    assign c_ax = SEED_W'(i_accel_x);
    assign c_ay = SEED_W'(i_accel_y);
    assign c_az = SEED_W'(i_accel_z);

    assign o_in_stall = i_queue.full;
    assign o_push     = i_in_valid && !i_queue.full;

    always_comb begin
        o_job.pitch  = classify(c_az, -c_ax);
        o_job.roll   = classify(c_az, c_ay);
        o_job.gyro_x = i_gyro_x;
        o_job.gyro_y = i_gyro_y;
        o_job.gyro_z = i_gyro_z;
    end

endmodule

@@ rtl/core/imucf_queue.sv @@
// short job queue between front and back
module imucf_queue
    import imucf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_status
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head         = r_mem[r_rptr];
    assign o_status.full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= (QPTR_W+1)'(QDEPTH)) && (r_count == '0 || r_count != '0 && 1'b1)
        |=> (r_count <= (QPTR_W+1)'(QDEPTH)))
        else $error("queue fill count beyond depth");

endmodule

@@ rtl/core/imucf_back.sv @@
// back part: iterative cordic, gyro integration, sequenced blend and result register
module imucf_back
    import imucf_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_job                      i_job,
    input  t_queue_status             i_queue,
    output logic                      o_pop,
    input  logic [BW_W-1:0]           i_blend_weight,
    input  logic [GAIN_W-1:0]         i_gyro_gain,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [ANGLE_W-1:0] o_roll_deg,
    output logic signed [ANGLE_W-1:0] o_pitch_deg,
    output logic signed [ANGLE_W-1:0] o_yaw_deg
);

    localparam int IW  = $clog2(CORDIC_STEPS);
    localparam int XW  = 40;
    localparam int ZW  = ANGLE_FRAC_BITS + 10;
    localparam int SH_UP = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
    localparam int SH_DN = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam logic signed [GSUM_W-1:0] RND =
        (ANGLE_FRAC_BITS > 16) ? GSUM_W'(1 << (ANGLE_FRAC_BITS - 17)) : '0;
    localparam logic signed [ZW-1:0] ZQUARTER = ZW'(90 * (1 << ANGLE_FRAC_BITS));
    localparam int PW = 18 + GSUM_W;
    localparam int GPW = AXIS_W + GAIN_W + 1;

    function automatic logic signed [XW-1:0] seed_xy(input logic signed [SEED_W-1:0] v);
        return {{(XW-SEED_W-20){v[SEED_W-1]}}, v, 20'b0};
    endfunction

    function automatic logic signed [ZW-1:0] seed_z(input t_prerot rot);
        logic signed [ZW-1:0] z;
        case (rot)
            ROT_POS: z = ZQUARTER;
            ROT_NEG: z = -ZQUARTER;
            default: z = '0;
        endcase
        return z;
    endfunction

    function automatic logic signed [GSUM_W-1:0] to_q16(input logic signed [ZW-1:0] z,
                                                        input logic zero);
        logic signed [GSUM_W-1:0] v;
        v = ((GSUM_W'(z) <<< SH_UP) + RND) >>> SH_DN;
        return zero ? '0 : v;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] round_sat(input logic signed [PW:0] s);
        logic signed [PW:0] t;
        t = (s + (PW+1)'(32768)) >>> 16;
        if (t > (PW+1)'(2147483647)) begin
            return 32'sh7FFFFFFF;
        end else if (t < (PW+1)'(-64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return t[ANGLE_W-1:0];
    endfunction

    t_back_state r_state;
    t_back_state n_state;
    logic [IW-1:0] r_iter;
    logic [2:0]    r_bstep;
    logic          n_load_out;

    t_job                     r_job;
    logic signed [XW-1:0]     r_px, r_py, r_rx, r_ry;
    logic signed [ZW-1:0]     r_pz, r_rz;
    logic signed [GPW-1:0]    r_gprod;
    logic signed [GSUM_W-1:0] r_roll_g, r_pitch_g, r_yaw_g;
    logic signed [GSUM_W-1:0] r_roll_a, r_pitch_a;
    logic signed [PW-1:0]     r_prod, r_acc;
    logic signed [ANGLE_W-1:0] r_roll, r_pitch, r_yaw;
    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_roll, r_out_pitch, r_out_yaw;

    logic                     c_last_iter;
    logic signed [ZW-1:0]     c_atan;
    logic signed [XW-1:0]     c_pdx, c_pdy, c_rdx, c_rdy;
    logic signed [AXIS_W-1:0] c_gsel;
    logic signed [GPW-1:0]    c_gprod;
    logic signed [GPW-1:0]    c_grnd;
    logic signed [ANGLE_W:0]  c_gstep;
    logic signed [ANGLE_W-1:0] c_gangle;
    logic signed [GSUM_W-1:0] c_gsum;
    logic [BW_W-1:0]          c_alpha;
    logic [BW_W-1:0]          c_beta;
    logic signed [17:0]       c_opa;
    logic signed [GSUM_W-1:0] c_opb;
    logic signed [PW-1:0]     c_prod;
    logic signed [PW:0]       c_pair;
    logic                     c_out_free;

    assign c_last_iter = (r_iter == IW'(CORDIC_STEPS - 1));
    assign c_out_free  = !r_out_valid || !i_out_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        n_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_queue.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (c_last_iter) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (r_bstep == 3'd6) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (c_out_free) begin
                    n_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cordic micro-rotation, one per cycle on both channels
    always_comb begin
        c_atan = signed'(ZW'(atan_step(5'(r_iter), ANGLE_FRAC_BITS)));
        c_pdx  = r_py >>> r_iter;
        c_pdy  = r_px >>> r_iter;
        c_rdx  = r_ry >>> r_iter;
        c_rdy  = r_rx >>> r_iter;
    end

    // gyro step, one axis per cycle during the first cordic cycles
    always_comb begin
        if (r_iter == IW'(0)) begin
            c_gsel = r_job.gyro_x;
        end else if (r_iter == IW'(1)) begin
            c_gsel = r_job.gyro_y;
        end else begin
            c_gsel = r_job.gyro_z;
        end
        c_gprod = c_gsel * signed'({1'b0, i_gyro_gain});
        c_grnd  = r_gprod + GPW'(128);
        c_gstep = (ANGLE_W+1)'(c_grnd >>> 8);
        if (r_iter == IW'(1)) begin
            c_gangle = r_roll;
        end else if (r_iter == IW'(2)) begin
            c_gangle = r_pitch;
        end else begin
            c_gangle = r_yaw;
        end
        c_gsum = GSUM_W'(c_gangle) + GSUM_W'(c_gstep);
    end

    // blend operands, one product per cycle
    always_comb begin
        c_alpha = (i_blend_weight > ALPHA_ONE) ? ALPHA_ONE : i_blend_weight;
        c_beta  = ALPHA_ONE - c_alpha;
        case (r_bstep)
            3'd1: begin
                c_opa = signed'({1'b0, c_alpha});
                c_opb = r_roll_g;
            end
            3'd2: begin
                c_opa = signed'({1'b0, c_beta});
                c_opb = r_roll_a;
            end
            3'd3: begin
                c_opa = signed'({1'b0, c_alpha});
                c_opb = r_pitch_g;
            end
            3'd4: begin
                c_opa = signed'({1'b0, c_beta});
                c_opb = r_pitch_a;
            end
            default: begin
                c_opa = signed'({1'b0, c_alpha});
                c_opb = r_yaw_g;
            end
        endcase
        c_prod = c_opa * c_opb;
        c_pair = (PW+1)'(r_acc) + (PW+1)'(r_prod);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_job  <= i_job;
                    r_px   <= seed_xy(i_job.pitch.x);
                    r_py   <= seed_xy(i_job.pitch.y);
                    r_pz   <= seed_z(i_job.pitch.rot);
                    r_rx   <= seed_xy(i_job.roll.x);
                    r_ry   <= seed_xy(i_job.roll.y);
                    r_rz   <= seed_z(i_job.roll.rot);
                    r_iter <= '0;
                end
            end
            ST_CORDIC: begin
                if (!r_py[XW-1]) begin
                    r_px <= r_px + c_pdx;
                    r_py <= r_py - c_pdy;
                    r_pz <= r_pz + c_atan;
                end else begin
                    r_px <= r_px - c_pdx;
                    r_py <= r_py + c_pdy;
                    r_pz <= r_pz - c_atan;
                end
                if (!r_ry[XW-1]) begin
                    r_rx <= r_rx + c_rdx;
                    r_ry <= r_ry - c_rdy;
                    r_rz <= r_rz + c_atan;
                end else begin
                    r_rx <= r_rx - c_rdx;
                    r_ry <= r_ry + c_rdy;
                    r_rz <= r_rz - c_atan;
                end
                r_gprod <= c_gprod;
                if (r_iter == IW'(1)) begin
                    r_roll_g <= c_gsum;
                end
                if (r_iter == IW'(2)) begin
                    r_pitch_g <= c_gsum;
                end
                if (r_iter == IW'(3)) begin
                    r_yaw_g <= c_gsum;
                end
                r_iter <= r_iter + 1'b1;
                if (c_last_iter) begin
                    r_bstep <= '0;
                end
            end
            ST_BLEND: begin
                r_bstep <= r_bstep + 1'b1;
                r_prod  <= c_prod;
                case (r_bstep)
                    3'd0: begin
                        r_roll_a  <= to_q16(r_rz, r_job.roll.zero);
                        r_pitch_a <= to_q16(r_pz, r_job.pitch.zero);
                    end
                    3'd2: r_acc <= r_prod;
                    3'd4: r_acc <= r_prod;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // stored angles, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else if (r_state == ST_BLEND) begin
            case (r_bstep)
                3'd3: r_roll  <= round_sat(c_pair);
                3'd5: r_pitch <= round_sat(c_pair);
                3'd6: r_yaw   <= round_sat((PW+1)'(r_prod));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= r_pitch;
            r_out_yaw   <= r_yaw;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_roll_deg  = r_out_roll;
    assign o_pitch_deg = r_out_pitch;
    assign o_yaw_deg   = r_out_yaw;

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CORDIC |-> r_iter <= IW'(CORDIC_STEPS - 1))
        else $error("cordic step count ran past its end");

endmodule

@@ rtl/core/imu_complementary_filter_core.sv @@
// top level of the imu complementary filter: config registers, front, queue and back
//
// one item is a six-axis sample; one result item (roll, pitch, yaw in signed q16.16
// degrees) comes back per item. each gyro rate is scaled by gyro_gain and added to the
// stored angle; accel pitch and roll come from two vectoring cordic units that run side
// by side, one micro-rotation per cycle; the gyro and accel angles are then blended
// through one shared multiplier, one product per cycle. in the back part an item passes
// through taking the job from the queue, the cordic iteration loop, the blend sequence
// and the hand-over of the result to the output register. the front part keeps accepting
// samples into a two-deep queue, until it is full, while the back part works, and a
// finished result waits in an output register without blocking the next item's
// computation start. config writes are always ready and should be made while the
// block is idle.
module imu_complementary_filter_core
    import imucf_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [AXIS_W-1:0]  i_accel_x,
    input  logic signed [AXIS_W-1:0]  i_accel_y,
    input  logic signed [AXIS_W-1:0]  i_accel_z,
    input  logic signed [AXIS_W-1:0]  i_gyro_x,
    input  logic signed [AXIS_W-1:0]  i_gyro_y,
    input  logic signed [AXIS_W-1:0]  i_gyro_z,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [ANGLE_W-1:0] o_roll_deg,
    output logic signed [ANGLE_W-1:0] o_pitch_deg,
    output logic signed [ANGLE_W-1:0] o_yaw_deg,
    // config write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic [BW_W-1:0]   r_blend_weight;
    logic [GAIN_W-1:0] r_gyro_gain;

    logic          c_push;
    logic          c_pop;
    t_job          c_front_job;
    t_job          c_head_job;
    t_queue_status c_queue;

    // config registers, alpha clamped to one inside the back part
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= BW_RESET;
            r_gyro_gain    <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data[BW_W-1:0];
                REG_GYRO_GAIN:    r_gyro_gain    <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // classify samples and push jobs
    imucf_front u_front (
        .i_in_valid (i_in_valid),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_gyro_x   (i_gyro_x),
        .i_gyro_y   (i_gyro_y),
        .i_gyro_z   (i_gyro_z),
        .i_queue    (c_queue),
        .o_in_stall (o_in_stall),
        .o_push     (c_push),
        .o_job      (c_front_job)
    );

    // decouples sample intake from the cordic and blend sequence
    imucf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (c_push),
        .i_job    (c_front_job),
        .i_pop    (c_pop),
        .o_head   (c_head_job),
        .o_status (c_queue)
    );

    // cordic, gyro integration, blend and result register
    imucf_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (c_head_job),
        .i_queue        (c_queue),
        .o_pop          (c_pop),
        .i_blend_weight (r_blend_weight),
        .i_gyro_gain    (r_gyro_gain),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_roll_deg     (o_roll_deg),
        .o_pitch_deg    (o_pitch_deg),
        .o_yaw_deg      (o_yaw_deg)
    );

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the imu complementary filter core
`timescale 1ns / 100ps

module tb_top
    import imucf_pkg::*;
;

    localparam int CORDIC_STEPS  = 16;
    localparam int ANGLE_FRAC    = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int SHOW_MAX      = 10;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_Q24 [24] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
    } t_imu_sample;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } t_attitude;

    // attitude predictor plus queue of expected angles
    class attitude_scoreboard;
        logic [BW_W-1:0]           alpha;
        logic [GAIN_W-1:0]         gain;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        t_attitude                 attitude_q[$];
        int                        n_samples;
        int                        n_results;
        int                        n_fail;

        function new();
            alpha     = BW_RESET;
            gain      = GAIN_RESET;
            roll      = '0;
            pitch     = '0;
            yaw       = '0;
            n_samples = 0;
            n_results = 0;
            n_fail    = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BLEND_WEIGHT: alpha = data[BW_W-1:0];
                REG_GYRO_GAIN:    gain  = data;
                default: ;
            endcase
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 << (s - 1))) >>> s;
        endfunction

        // vectoring cordic atan2 in q16.16 degrees
        function longint accel_angle(longint y_in, longint x_in);
            longint x;
            longint y;
            longint z;
            longint t;
            longint dx;
            longint dy;
            longint step;
            x = x_in * 1048576;
            y = y_in * 1048576;
            z = 0;
            if (x_in == 0 && y_in == 0) begin
                return 0;
            end
            // quarter turn first when the vector points left
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t;
                    z = round_shift(ATAN_Q24[0] * 2, 24 - ANGLE_FRAC);
                end else begin
                    t = x; x = -y; y = t;
                    z = -round_shift(ATAN_Q24[0] * 2, 24 - ANGLE_FRAC);
                end
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                dx   = y >>> i;
                dy   = x >>> i;
                step = round_shift(ATAN_Q24[i], 24 - ANGLE_FRAC);
                if (y >= 0) begin
                    x += dx; y -= dy; z += step;
                end else begin
                    x -= dx; y += dy; z -= step;
                end
            end
            if (ANGLE_FRAC <= 16) begin
                return z * (64'sd1 << (16 - ANGLE_FRAC));
            end
            return round_shift(z, ANGLE_FRAC - 16);
        endfunction

        function logic signed [ANGLE_W-1:0] blend_angle(longint w, longint g, longint acc);
            longint q;
            q = (w * g + (65536 - w) * acc + 32768) >>> 16;
            if (q > 64'sd2147483647) begin
                return 32'sh7fffffff;
            end
            if (q < -64'sd2147483648) begin
                return 32'sh80000000;
            end
            return ANGLE_W'(q);
        endfunction

        function void note_sample(t_imu_sample s);
            longint    w;
            longint    roll_g;
            longint    pitch_g;
            longint    yaw_g;
            longint    roll_a;
            longint    pitch_a;
            t_attitude nxt;
            w = (alpha > ALPHA_ONE) ? 65536 : longint'(alpha);
            roll_g  = longint'(roll)  + round_shift(longint'(s.gyro_x) * longint'(gain), 8);
            pitch_g = longint'(pitch) + round_shift(longint'(s.gyro_y) * longint'(gain), 8);
            yaw_g   = longint'(yaw)   + round_shift(longint'(s.gyro_z) * longint'(gain), 8);
            pitch_a = accel_angle(-longint'(s.accel_x), longint'(s.accel_z));
            roll_a  = accel_angle(longint'(s.accel_y), longint'(s.accel_z));
            roll  = blend_angle(w, roll_g, roll_a);
            pitch = blend_angle(w, pitch_g, pitch_a);
            yaw   = blend_angle(w, yaw_g, 0);
            nxt.roll  = roll;
            nxt.pitch = pitch;
            nxt.yaw   = yaw;
            attitude_q.push_back(nxt);
            n_samples++;
        endfunction

        function void check_result(t_attitude got);
            t_attitude want;
            n_results++;
            if (attitude_q.size() == 0) begin
                n_fail++;
                if (n_fail <= SHOW_MAX) begin
                    $display("unexpected result roll=%0d pitch=%0d yaw=%0d",
                             got.roll, got.pitch, got.yaw);
                end
                return;
            end
            want = attitude_q.pop_front();
            if (got.roll !== want.roll || got.pitch !== want.pitch
                    || got.yaw !== want.yaw) begin
                n_fail++;
                if (n_fail <= SHOW_MAX) begin
                    $display("result %0d mismatch: roll exp %0d got %0d,",
                             n_results, want.roll, got.roll);
                    $display("    pitch exp %0d got %0d, yaw exp %0d got %0d",
                             want.pitch, got.pitch, want.yaw, got.yaw);
                end
            end
        endfunction

        function int pending();
            return attitude_q.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [AXIS_W-1:0]  i_accel_x = '0;
    logic signed [AXIS_W-1:0]  i_accel_y = '0;
    logic signed [AXIS_W-1:0]  i_accel_z = '0;
    logic signed [AXIS_W-1:0]  i_gyro_x = '0;
    logic signed [AXIS_W-1:0]  i_gyro_y = '0;
    logic signed [AXIS_W-1:0]  i_gyro_z = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [ANGLE_W-1:0] o_roll_deg;
    logic signed [ANGLE_W-1:0] o_pitch_deg;
    logic signed [ANGLE_W-1:0] o_yaw_deg;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    attitude_scoreboard sb = new();
    bit                 steady = 1'b0;   // both sides run without idling
    int                 n_cfg_writes = 0;

    imu_complementary_filter_core #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_gyro_x    (i_gyro_x),
        .i_gyro_y    (i_gyro_y),
        .i_gyro_z    (i_gyro_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_roll_deg  (o_roll_deg),
        .o_pitch_deg (o_pitch_deg),
        .o_yaw_deg   (o_yaw_deg),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // one register write; the caller lowers valid after its last write
    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.write_reg(idx, data);
        n_cfg_writes++;
    endtask

    task automatic set_config(logic [BW_W-1:0] w, logic [GAIN_W-1:0] g);
        cfg_write(REG_BLEND_WEIGHT, CFG_DATA_W'(w));
        cfg_write(REG_GYRO_GAIN, g);
        i_cfg_valid <= 1'b0;
    endtask

    // drive one item, with a random lead-in gap outside steady mode, and hold it until taken
    task automatic send_sample(t_imu_sample s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x  <= s.accel_x;
        i_accel_y  <= s.accel_y;
        i_accel_z  <= s.accel_z;
        i_gyro_x   <= s.gyro_x;
        i_gyro_y   <= s.gyro_y;
        i_gyro_z   <= s.gyro_z;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_sample(s);
    endtask

    task automatic push(int ax, int ay, int az, int gx, int gy, int gz);
        t_imu_sample s;
        s.accel_x = AXIS_W'(ax);
        s.accel_y = AXIS_W'(ay);
        s.accel_z = AXIS_W'(az);
        s.gyro_x  = AXIS_W'(gx);
        s.gyro_y  = AXIS_W'(gy);
        s.gyro_z  = AXIS_W'(gz);
        send_sample(s);
    endtask

    function automatic int any_axis();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // mostly sensor-like samples near 1 g with modest rates, the rest anything
    task automatic run_random(int count);
        int az;
        repeat (count) begin
            if ($urandom_range(0, 9) < 6) begin
                az = 16384 + int'($urandom_range(0, 4000)) - 2000;
                if ($urandom_range(0, 7) == 0) begin
                    az = -az;   // board upside down
                end
                push(int'($urandom_range(0, 16000)) - 8000,
                     int'($urandom_range(0, 16000)) - 8000, az,
                     int'($urandom_range(0, 1000)) - 500,
                     int'($urandom_range(0, 1000)) - 500,
                     int'($urandom_range(0, 1000)) - 500);
            end else begin
                push(any_axis(), any_axis(), any_axis(), any_axis(), any_axis(), any_axis());
            end
        end
    endtask

    // stop sending and let every expected result come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result side: random stall before each result outside steady mode, check at the accepting edge
    initial begin
        t_attitude got;
        int        hold;
        wait (i_rst_n);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
            got.roll  = o_roll_deg;
            got.pitch = o_pitch_deg;
            got.yaw   = o_yaw_deg;
            sb.check_result(got);
        end
    end

    // watchdog: too long with no handshake on any channel ends the run
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, directed corners first
        push(0, 0, 0, 0, 0, 0);                     // atan2 of zero vector
        push(0, 0, -16384, 0, 0, 0);                // zero over negative gives +180
        push(100, -100, -16384, 0, 0, 0);           // left half, y below axis
        push(-100, 100, -1, 0, 0, 0);               // left half, y above axis
        push(-32768, 32767, 0, 0, 0, 0);            // x zero, y at extremes
        push(32767, -32768, 0, 0, 0, 0);
        push(0, 0, 32767, 0, 0, 0);
        push(32767, 32767, -32768, 0, 0, 0);
        push(-32768, -32768, -32768, 32767, -32768, 32767);
        push(1, -1, 1, -32768, 32767, -32768);
        push(-1, 1, 0, 1, -1, 1);
        repeat (4) push(0, 16384, 16384, 32767, 32767, -32768);
        push(16384, 0, -32768, -1, -1, -1);
        push(32767, -32768, 32767, 0, 0, 0);
        run_random(100);
        drain();

        // pure gyro at full gain: angles run into saturation both ways
        set_config(ALPHA_ONE, 24'hffffff);
        repeat (4) push(0, 0, 16384, 32767, -32768, 32767);
        repeat (6) push(0, 0, 16384, -32768, 32767, -32768);
        run_random(50);
        drain();

        // pure accel, no gyro contribution
        set_config('0, '0);
        run_random(70);
        drain();

        // weight above one is clamped to one
        set_config(17'h1ffff, GAIN_W'($urandom));
        run_random(50);
        drain();

        // smallest nonzero settings
        set_config(17'd1, 24'd1);
        run_random(50);
        drain();

        // random weight, back-to-back traffic on both sides
        steady = 1'b1;
        set_config(BW_W'($urandom_range(0, 65536)), GAIN_RESET);
        run_random(60);
        drain();
        steady = 1'b0;

        // reset values written back explicitly
        set_config(BW_RESET, GAIN_RESET);
        run_random(60);
        drain();

        // let any stray result show up before judging
        repeat (40) @(posedge i_clk);

        $display("run: %0d samples, %0d results checked, %0d register writes, %0d failures",
                 sb.n_samples, sb.n_results, n_cfg_writes, sb.n_fail);
        $display("covered: cordic corners, gyro saturation, weight 0 / 1 / above one, gain 0..max");
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
